/* rtl/core/hbe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Hermite basis evaluator package
// Shared widths, status codes, basis coefficient tables and item control type.
// ----------------------------------------------------------------------------
package hbe_pkg;

   localparam int IN_W    = 32;
   localparam int OUT_W   = 64;
   localparam int DER_W   = 3;
   localparam int LANES   = 6;
   localparam int TERMS   = 6;
   localparam int DEG_MAX = 5;
   localparam int MONO_W  = IN_W * DEG_MAX;
   localparam int COEF_W  = 11;
   localparam int PROD_W  = MONO_W + 1 + COEF_W;
   localparam int SUM_W   = PROD_W + 3;
   localparam int QUO_W   = OUT_W + 1;

   localparam int IN_FRAC_BITS_DEF  = 16;
   localparam int OUT_FRAC_BITS_DEF = 32;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_LEN = 2'd1;
   localparam logic [1:0] ST_SAT      = 2'd2;

   localparam logic [DER_W-1:0] DEG_CUBIC   = 3'd3;
   localparam logic [DER_W-1:0] DEG_QUINTIC = 3'd5;

   // coefficient j multiplies x^j h^(deg-j)
   localparam int CUB_POLY [4][6] = '{
      '{1, 0, -3, 2, 0, 0}, '{0, 0, 3, -2, 0, 0},
      '{0, 1, -2, 1, 0, 0}, '{0, 0, -1, 1, 0, 0}};
   localparam int QUIN_POLY [6][6] = '{
      '{1, 0, 0, -10, 15, -6}, '{0, 0, 0, 10, -15, 6},
      '{0, 1, 0, -6, 8, -3},   '{0, 0, 0, -4, 7, -3},
      '{0, 0, 1, -3, 3, -1},   '{0, 0, 0, 1, -2, 1}};
   localparam int CUB_M [4]  = '{3, 3, 2, 2};
   localparam int QUIN_M [6] = '{5, 5, 4, 4, 3, 3};

   typedef struct packed {
      logic             quin;
      logic [DER_W-1:0] d;
      logic [DER_W-1:0] k;     // degree of the monomial row in use
      logic             zb;    // zero interval length
      logic             kill;  // all lanes zero
   } ctl_type;

   typedef struct packed {
      logic [TERMS-1:0][MONO_W-1:0] row;
      logic [TERMS-1:0][MONO_W-1:0] sel;
      logic [TERMS-1:0][MONO_W-1:0] bpow;
      logic [IN_W-1:0]              a;
      logic [IN_W-1:0]              b;
      ctl_type                      ctl;
   } mono_type;

   // derivative coefficient of monomial a^j b^(k-j) in a lane
   function automatic logic signed [COEF_W-1:0] coef(logic quin, logic [DER_W-1:0] d,
                                                     int lane, int j);
      int deg;
      int p;
      int g;
      deg = quin ? 5 : 3;
      g   = 0;
      p   = j + int'(d);
      if (p <= deg && (quin || lane < 4)) begin
         g = quin ? QUIN_POLY[lane][p] : CUB_POLY[lane][p];
         for (int t = 1; t <= DEG_MAX; t++) begin
            if (t > j && t <= p) g = g * t;
         end
      end
      return COEF_W'(g);
   endfunction

   function automatic int lane_m(logic quin, int lane);
      int m;
      m = 3;
      if (quin) m = QUIN_M[lane];
      else if (lane < 4) m = CUB_M[lane];
      return m;
   endfunction

   function automatic int sh_pos(int ifb, int ofb);
      return ofb + ifb * DEG_MAX;
   endfunction

   function automatic int sh_neg(int ifb, int ofb);
      return (2 * ifb > ofb) ? 2 * ifb - ofb : 0;
   endfunction

   function automatic int num2_w(int ifb, int ofb);
      return SUM_W + sh_pos(ifb, ofb) + 2;
   endfunction

   function automatic int den2_w(int ifb, int ofb);
      return MONO_W + 2 + sh_neg(ifb, ofb) + 1;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/hbe_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Hermite basis evaluator channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface hbe_req_if;
   logic                        valid;
   logic                        ready;
   logic [hbe_pkg::IN_W-1:0]    position;
   logic [hbe_pkg::IN_W-1:0]    interval_len;
   logic                        quintic;
   logic [hbe_pkg::DER_W-1:0]   deriv_order;

   modport source (output valid, position, interval_len, quintic, deriv_order,
                   input ready);
   modport sink   (input valid, position, interval_len, quintic, deriv_order,
                   output ready);
endinterface

interface hbe_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [hbe_pkg::OUT_W-1:0]   basis_0;
   logic signed [hbe_pkg::OUT_W-1:0]   basis_1;
   logic signed [hbe_pkg::OUT_W-1:0]   basis_2;
   logic signed [hbe_pkg::OUT_W-1:0]   basis_3;
   logic signed [hbe_pkg::OUT_W-1:0]   basis_4;
   logic signed [hbe_pkg::OUT_W-1:0]   basis_5;
   logic [1:0]                         status;

   modport source (output valid, basis_0, basis_1, basis_2, basis_3, basis_4, basis_5,
                   status, input ready);
   modport sink   (input valid, basis_0, basis_1, basis_2, basis_3, basis_4, basis_5,
                   status, output ready);
endinterface
`default_nettype wire

/* rtl/core/hermite_basis_evaluator_core.sv */
// Pipeline: 75 register stages between request transfer and response valid
//   (6 monomial, 3 lane, 65 quotient-bit, 1 output).
// Throughput: one item per cycle while the response is taken; each stage holds on its own
//   under backpressure, so bubbles close up and the input moves on while free stages remain.
// Reset: synchronous, active high; clears all stage valid bits, data is not reset.
`default_nettype none
// ----------------------------------------------------------------------------
// Hermite basis evaluator core
// Cubic and quintic Hermite basis values and derivatives, signed fixed point.
// ----------------------------------------------------------------------------
module hermite_basis_evaluator_core #(
   parameter int IN_FRAC_BITS  = hbe_pkg::IN_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS = hbe_pkg::OUT_FRAC_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hbe_req_if.sink    req_ch,
   hbe_rsp_if.source  rsp_ch
);

   localparam int NUM2_W = hbe_pkg::num2_w(IN_FRAC_BITS, OUT_FRAC_BITS);
   localparam int DEN2_W = hbe_pkg::den2_w(IN_FRAC_BITS, OUT_FRAC_BITS);
   localparam int LANES  = hbe_pkg::LANES;

   logic              mono_valid;
   logic              mono_ready;
   hbe_pkg::mono_type mono_data;

   logic                    ln_valid;
   logic                    ln_ready;
   logic [NUM2_W-1:0]       ln_num2 [LANES];
   logic [DEN2_W-1:0]       ln_den2 [LANES];
   logic [LANES-1:0]        ln_neg;
   logic [LANES-1:0]        ln_zero;
   logic                    ln_zb;

   logic [hbe_pkg::OUT_W-1:0] basis [LANES];

   hbe_mono u_mono (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_a      (req_ch.position),
      .in_b      (req_ch.interval_len),
      .in_quin   (req_ch.quintic),
      .in_d      (req_ch.deriv_order),
      .out_valid (mono_valid),
      .out_ready (mono_ready),
      .out_data  (mono_data)
   );

   hbe_lanes #(
      .IN_FRAC_BITS  (IN_FRAC_BITS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS),
      .NUM2_W        (NUM2_W),
      .DEN2_W        (DEN2_W)
   ) u_lanes (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mono_valid),
      .in_ready  (mono_ready),
      .in_data   (mono_data),
      .out_valid (ln_valid),
      .out_ready (ln_ready),
      .out_num2  (ln_num2),
      .out_den2  (ln_den2),
      .out_neg   (ln_neg),
      .out_zero  (ln_zero),
      .out_zb    (ln_zb)
   );

   hbe_div #(
      .NUM2_W (NUM2_W),
      .DEN2_W (DEN2_W)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (ln_valid),
      .in_ready   (ln_ready),
      .in_num2    (ln_num2),
      .in_den2    (ln_den2),
      .in_neg     (ln_neg),
      .in_zero    (ln_zero),
      .in_zb      (ln_zb),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_basis  (basis),
      .out_status (rsp_ch.status)
   );

   assign rsp_ch.basis_0 = basis[0];
   assign rsp_ch.basis_1 = basis[1];
   assign rsp_ch.basis_2 = basis[2];
   assign rsp_ch.basis_3 = basis[3];
   assign rsp_ch.basis_4 = basis[4];
   assign rsp_ch.basis_5 = basis[5];

endmodule
`default_nettype wire

/* rtl/core/hbe_mono.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Monomial pipeline
// Builds rows a^j b^(p-j) one degree per stage and keeps the row and the
// powers of b that the lanes need.
// ----------------------------------------------------------------------------
module hbe_mono (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [hbe_pkg::IN_W-1:0]   in_a,
   input  wire logic [hbe_pkg::IN_W-1:0]   in_b,
   input  wire logic                       in_quin,
   input  wire logic [hbe_pkg::DER_W-1:0]  in_d,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output hbe_pkg::mono_type               out_data
);

   localparam int NS    = hbe_pkg::DEG_MAX + 1;
   localparam int IN_W  = hbe_pkg::IN_W;
   localparam int LIMBS = hbe_pkg::DEG_MAX;

   hbe_pkg::mono_type st_ff [NS];
   hbe_pkg::mono_type st_in [NS];
   logic [NS-1:0]     v_ff;
   logic [NS-1:0]     v_in;
   logic [NS-1:0]     adv;

   // row entry times one 32-bit word, built from 32x32 limb products
   function automatic logic [hbe_pkg::MONO_W-1:0] mul_word(
      logic [hbe_pkg::MONO_W-1:0] v, logic [IN_W-1:0] w);
      logic [2*IN_W-1:0]               pp;
      logic [hbe_pkg::MONO_W+IN_W-1:0] ev;
      logic [hbe_pkg::MONO_W+IN_W-1:0] od;
      logic [hbe_pkg::MONO_W+IN_W-1:0] sum;
      ev = '0;
      od = '0;
      for (int i = 0; i < LIMBS; i++) begin
         pp = v[i*IN_W +: IN_W] * w;
         // even and odd limb products each tile without overlap
         if ((i & 1) == 0) ev[i*IN_W +: 2*IN_W] = pp;
         else od[i*IN_W +: 2*IN_W] = pp;
      end
      sum = ev + od;
      return sum[hbe_pkg::MONO_W-1:0];
   endfunction

   always_comb begin
      for (int s = NS - 1; s >= 0; s--) begin
         if (s == NS - 1) adv[s] = !v_ff[s] || out_ready;
         else adv[s] = !v_ff[s] || adv[s+1];
      end
      v_in = {v_ff[NS-2:0], in_valid};
   end

   always_comb begin
      logic [hbe_pkg::DER_W-1:0] deg;
      deg                 = in_quin ? hbe_pkg::DEG_QUINTIC : hbe_pkg::DEG_CUBIC;
      st_in[0]            = '0;
      st_in[0].a          = in_a;
      st_in[0].b          = in_b;
      st_in[0].ctl.quin   = in_quin;
      st_in[0].ctl.d      = in_d;
      st_in[0].ctl.zb     = (in_b == '0);
      st_in[0].ctl.kill   = (in_b == '0) || (in_d > deg);
      st_in[0].ctl.k      = st_in[0].ctl.kill ? '0 : deg - in_d;
      st_in[0].row[0]     = hbe_pkg::MONO_W'(1);
      st_in[0].bpow[0]    = hbe_pkg::MONO_W'(1);
      if (st_in[0].ctl.k == '0) st_in[0].sel = st_in[0].row;
   end

   for (genvar p = 1; p < NS; p++) begin : g_deg
      always_comb begin
         st_in[p] = st_ff[p-1];
         for (int j = 0; j < hbe_pkg::TERMS; j++) begin
            if (j < p) st_in[p].row[j] = mul_word(st_ff[p-1].row[j], st_ff[p-1].b);
         end
         st_in[p].row[p]  = mul_word(st_ff[p-1].row[p-1], st_ff[p-1].a);
         st_in[p].bpow[p] = st_in[p].row[0];
         if (st_ff[p-1].ctl.k == hbe_pkg::DER_W'(p)) st_in[p].sel = st_in[p].row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (adv[s]) v_ff[s] <= v_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NS; s++) begin
         if (adv[s]) st_ff[s] <= st_in[s];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[NS-1];
   assign out_data  = st_ff[NS-1];

endmodule
`default_nettype wire

/* rtl/core/hbe_lanes.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Lane numerators and denominators
// Weights the monomial row per lane, sums, takes the magnitude and scales
// numerator and denominator for a rounded quotient.
// ----------------------------------------------------------------------------
module hbe_lanes #(
   parameter int IN_FRAC_BITS  = hbe_pkg::IN_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS = hbe_pkg::OUT_FRAC_BITS_DEF,
   parameter int NUM2_W        = hbe_pkg::num2_w(IN_FRAC_BITS, OUT_FRAC_BITS),
   parameter int DEN2_W        = hbe_pkg::den2_w(IN_FRAC_BITS, OUT_FRAC_BITS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire hbe_pkg::mono_type      in_data,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [NUM2_W-1:0]           out_num2 [hbe_pkg::LANES],
   output logic [DEN2_W-1:0]           out_den2 [hbe_pkg::LANES],
   output logic [hbe_pkg::LANES-1:0]   out_neg,
   output logic [hbe_pkg::LANES-1:0]   out_zero,
   output logic                        out_zb
);

   localparam int LANES  = hbe_pkg::LANES;
   localparam int TERMS  = hbe_pkg::TERMS;
   localparam int SUM_W  = hbe_pkg::SUM_W;
   localparam int PROD_W = hbe_pkg::PROD_W;
   localparam int DEN0_W = hbe_pkg::MONO_W + 2;
   localparam int DEN_W  = DEN2_W - 1;
   localparam int SH_POS = hbe_pkg::sh_pos(IN_FRAC_BITS, OUT_FRAC_BITS);
   localparam int SH_NEG = hbe_pkg::sh_neg(IN_FRAC_BITS, OUT_FRAC_BITS);
   localparam int SHN_W  = $clog2(SH_POS + 2);
   localparam int SHD_W  = $clog2(SH_NEG + 2);

   logic [2:0] v_ff;
   logic [2:0] adv;

   // stage A: weighted monomials
   logic signed [PROD_W-1:0] prod_ff [LANES][TERMS];
   logic signed [PROD_W-1:0] prod_in [LANES][TERMS];
   logic [TERMS-1:0][hbe_pkg::MONO_W-1:0] bpow_a_ff;
   hbe_pkg::ctl_type ctl_a_ff;

   // stage B: magnitude, denominator, shift amounts
   logic [SUM_W-1:0]  mag_ff [LANES];
   logic [SUM_W-1:0]  mag_in [LANES];
   logic [DEN0_W-1:0] den_ff [LANES];
   logic [DEN0_W-1:0] den_in [LANES];
   logic [SHN_W-1:0]  shn_ff [LANES];
   logic [SHN_W-1:0]  shn_in [LANES];
   logic [SHD_W-1:0]  shd_ff [LANES];
   logic [SHD_W-1:0]  shd_in [LANES];
   logic [LANES-1:0]  neg_b_ff;
   logic [LANES-1:0]  neg_b_in;
   hbe_pkg::ctl_type  ctl_b_ff;

   // stage C: rounding numerator and doubled denominator
   logic [NUM2_W-1:0] num2_ff [LANES];
   logic [NUM2_W-1:0] num2_in [LANES];
   logic [DEN2_W-1:0] den2_ff [LANES];
   logic [DEN2_W-1:0] den2_in [LANES];
   logic [LANES-1:0]  neg_c_ff;
   logic [LANES-1:0]  zero_c_ff;
   logic [LANES-1:0]  zero_c_in;
   logic              zb_c_ff;

   always_comb begin
      adv[2] = !v_ff[2] || out_ready;
      adv[1] = !v_ff[1] || adv[2];
      adv[0] = !v_ff[0] || adv[1];
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      always_comb begin
         for (int j = 0; j < TERMS; j++) begin
            prod_in[l][j] = hbe_pkg::coef(in_data.ctl.quin, in_data.ctl.d, l, j)
                            * $signed({1'b0, in_data.sel[j]});
         end
      end

      always_comb begin
         logic signed [SUM_W-1:0] acc;
         int m;
         int sh;
         acc = '0;
         for (int j = 0; j < TERMS; j++) acc = acc + SUM_W'(prod_ff[l][j]);
         neg_b_in[l] = acc[SUM_W-1];
         mag_in[l]   = neg_b_in[l] ? SUM_W'(-acc) : SUM_W'(acc);
         m = hbe_pkg::lane_m(ctl_a_ff.quin, l);
         // quintic lanes 4 and 5 carry a factor of one half
         if (ctl_a_ff.quin && l >= 4) den_in[l] = {bpow_a_ff[m], 1'b0} & {DEN0_W{1'b1}};
         else den_in[l] = DEN0_W'(bpow_a_ff[m]);
         sh = OUT_FRAC_BITS + IN_FRAC_BITS * (m - int'(ctl_a_ff.k));
         shn_in[l] = (sh > 0) ? SHN_W'(sh) : '0;
         shd_in[l] = (sh < 0) ? SHD_W'(-sh) : '0;
      end

      always_comb begin
         logic [NUM2_W-1:0] num;
         logic [DEN_W-1:0]  dn;
         num = NUM2_W'(mag_ff[l]) << shn_ff[l];
         dn  = DEN_W'(den_ff[l]) << shd_ff[l];
         // round half away from zero: (2*mag + den) / (2*den)
         num2_in[l]  = (num << 1) + NUM2_W'(dn);
         den2_in[l]  = {dn, 1'b0};
         zero_c_in[l] = ctl_b_ff.kill || (!ctl_b_ff.quin && l >= 4);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
         if (adv[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         prod_ff   <= prod_in;
         bpow_a_ff <= in_data.bpow;
         ctl_a_ff  <= in_data.ctl;
      end
      if (adv[1]) begin
         mag_ff   <= mag_in;
         den_ff   <= den_in;
         shn_ff   <= shn_in;
         shd_ff   <= shd_in;
         neg_b_ff <= neg_b_in;
         ctl_b_ff <= ctl_a_ff;
      end
      if (adv[2]) begin
         num2_ff   <= num2_in;
         den2_ff   <= den2_in;
         neg_c_ff  <= neg_b_ff;
         zero_c_ff <= zero_c_in;
         zb_c_ff   <= ctl_b_ff.zb;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[2];
   assign out_num2  = num2_ff;
   assign out_den2  = den2_ff;
   assign out_neg   = neg_c_ff;
   assign out_zero  = zero_c_ff;
   assign out_zb    = zb_c_ff;

endmodule
`default_nettype wire

/* rtl/core/hbe_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage for all lanes, then saturation, sign and status.
// ----------------------------------------------------------------------------
module hbe_div #(
   parameter int NUM2_W = hbe_pkg::num2_w(hbe_pkg::IN_FRAC_BITS_DEF,
                                          hbe_pkg::OUT_FRAC_BITS_DEF),
   parameter int DEN2_W = hbe_pkg::den2_w(hbe_pkg::IN_FRAC_BITS_DEF,
                                          hbe_pkg::OUT_FRAC_BITS_DEF)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [NUM2_W-1:0]             in_num2 [hbe_pkg::LANES],
   input  wire logic [DEN2_W-1:0]             in_den2 [hbe_pkg::LANES],
   input  wire logic [hbe_pkg::LANES-1:0]     in_neg,
   input  wire logic [hbe_pkg::LANES-1:0]     in_zero,
   input  wire logic                          in_zb,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [hbe_pkg::OUT_W-1:0]          out_basis [hbe_pkg::LANES],
   output logic [1:0]                         out_status
);

   localparam int LANES = hbe_pkg::LANES;
   localparam int QUO_W = hbe_pkg::QUO_W;
   localparam int OUT_W = hbe_pkg::OUT_W;
   localparam int RW    = (NUM2_W > DEN2_W + QUO_W) ? NUM2_W : DEN2_W + QUO_W;
   localparam int NS    = QUO_W + 1;

   logic [RW-1:0]     rem_ff  [QUO_W][LANES];
   logic [RW-1:0]     rem_in  [QUO_W][LANES];
   logic [DEN2_W-1:0] den_ff  [QUO_W][LANES];
   logic [QUO_W-1:0]  q_ff    [QUO_W][LANES];
   logic [QUO_W-1:0]  q_in    [QUO_W][LANES];
   logic [LANES-1:0]  neg_ff  [QUO_W];
   logic [LANES-1:0]  zero_ff [QUO_W];
   logic              zb_ff   [QUO_W];

   logic [OUT_W-1:0]  basis_ff [LANES];
   logic [OUT_W-1:0]  basis_in [LANES];
   logic [1:0]        status_ff;
   logic [1:0]        status_in;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] adv;

   always_comb begin
      for (int s = NS - 1; s >= 0; s--) begin
         if (s == NS - 1) adv[s] = !v_ff[s] || out_ready;
         else adv[s] = !v_ff[s] || adv[s+1];
      end
   end

   for (genvar s = 0; s < QUO_W; s++) begin : g_bit
      localparam int BIT = QUO_W - 1 - s;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         always_comb begin
            logic [RW-1:0]     r;
            logic [RW-1:0]     trial;
            logic [QUO_W-1:0]  q;
            if (s == 0) begin
               r = RW'(in_num2[l]);
               trial = RW'(in_den2[l]) << BIT;
               q = '0;
            end else begin
               r = rem_ff[s-1][l];
               trial = RW'(den_ff[s-1][l]) << BIT;
               q = q_ff[s-1][l];
            end
            if (r >= trial) begin
               rem_in[s][l] = r - trial;
               q[BIT] = 1'b1;
            end else begin
               rem_in[s][l] = r;
            end
            q_in[s][l] = q;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
            if (s == 0) begin
               den_ff[s]  <= in_den2;
               neg_ff[s]  <= in_neg;
               zero_ff[s] <= in_zero;
               zb_ff[s]   <= in_zb;
            end else begin
               den_ff[s]  <= den_ff[s-1];
               neg_ff[s]  <= neg_ff[s-1];
               zero_ff[s] <= zero_ff[s-1];
               zb_ff[s]   <= zb_ff[s-1];
            end
         end
      end
   end

   always_comb begin
      logic [LANES-1:0] sat;
      logic [QUO_W-1:0] q;
      logic             n;
      sat = '0;
      for (int l = 0; l < LANES; l++) begin
         q = q_ff[QUO_W-1][l];
         n = neg_ff[QUO_W-1][l];
         basis_in[l] = '0;
         if (!zero_ff[QUO_W-1][l]) begin
            // negative side reaches one further than positive
            sat[l] = q[QUO_W-1] || (!n && q[OUT_W-1])
                     || (n && q[OUT_W-1] && (|q[OUT_W-2:0]));
            if (sat[l]) basis_in[l] = n ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
            else if (n) basis_in[l] = -q[OUT_W-1:0];
            else basis_in[l] = q[OUT_W-1:0];
         end
      end
      if (zb_ff[QUO_W-1]) status_in = hbe_pkg::ST_ZERO_LEN;
      else if (|sat) status_in = hbe_pkg::ST_SAT;
      else status_in = hbe_pkg::ST_OK;
   end

   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         basis_ff  <= basis_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (adv[s]) v_ff[s] <= (s == 0) ? in_valid : v_ff[s-1];
         end
      end
   end

   assign in_ready   = adv[0];
   assign out_valid  = v_ff[NS-1];
   assign out_basis  = basis_ff;
   assign out_status = status_ff;

endmodule
`default_nettype wire

/* rtl/core/hbe_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Hermite basis evaluator port checker
// Response channel and status consistency checks, bound to the core.
// ----------------------------------------------------------------------------
module hbe_chk (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [hbe_pkg::OUT_W-1:0]  b0,
   input wire logic [hbe_pkg::OUT_W-1:0]  b1,
   input wire logic [hbe_pkg::OUT_W-1:0]  b2,
   input wire logic [hbe_pkg::OUT_W-1:0]  b3,
   input wire logic [hbe_pkg::OUT_W-1:0]  b4,
   input wire logic [hbe_pkg::OUT_W-1:0]  b5,
   input wire logic [1:0]                 status
);

   localparam logic [hbe_pkg::OUT_W-1:0] VMAX = {1'b0, {(hbe_pkg::OUT_W-1){1'b1}}};
   localparam logic [hbe_pkg::OUT_W-1:0] VMIN = {1'b1, {(hbe_pkg::OUT_W-1){1'b0}}};

   // a stalled response stays valid and keeps lanes 0 and 5 and its status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(b0) && $stable(b5) && $stable(status))
      else $error("response changed under stall");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == hbe_pkg::ST_ZERO_LEN |->
         b0 == '0 && b1 == '0 && b2 == '0 && b3 == '0 && b4 == '0 && b5 == '0)
      else $error("zero interval length with nonzero basis");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == hbe_pkg::ST_SAT |->
         b0 == VMAX || b0 == VMIN || b1 == VMAX || b1 == VMIN || b2 == VMAX || b2 == VMIN
         || b3 == VMAX || b3 == VMIN || b4 == VMAX || b4 == VMIN || b5 == VMAX
         || b5 == VMIN)
      else $error("saturation status without a clamped lane");

endmodule

bind hermite_basis_evaluator_core hbe_chk u_hbe_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .b0        (rsp_ch.basis_0),
   .b1        (rsp_ch.basis_1),
   .b2        (rsp_ch.basis_2),
   .b3        (rsp_ch.basis_3),
   .b4        (rsp_ch.basis_4),
   .b5        (rsp_ch.basis_5),
   .status    (rsp_ch.status)
);
`default_nettype wire
